/* sv/ptfm_pkg.sv */
// shared types and constants for the page table frame manager
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ptfm_pkg;

  localparam int PAGES   = 1024;
  localparam int PAGE_W  = 10;
  localparam int FRAMES  = 256;
  localparam int FRAME_W = 8;
  localparam int CAP_W   = 9;
  localparam int TIME_W  = 32;
  localparam int FLAG_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // flag bit positions inside an entry
  localparam int FLAG_VALID  = 0;
  localparam int FLAG_DIRTY  = 1;
  localparam int FLAG_SECOND = 2;

  localparam logic [FLAG_W-1:0] LOAD_FLAGS = 3'b101;

  typedef enum logic [2:0] {
    CMD_READ       = 3'd0,
    CMD_PLACE      = 3'd1,
    CMD_REPLACE    = 3'd2,
    CMD_TOUCH      = 3'd3,
    CMD_SET_VALID  = 3'd4,
    CMD_SET_DIRTY  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [FLAG_W-1:0]  flags;
    logic [TIME_W-1:0]  load_stamp;
    logic [TIME_W-1:0]  use_stamp;
  } entry_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [PAGE_W-1:0]  page;
    logic [PAGE_W-1:0]  victim;
    logic               flag;
    logic [TIME_W-1:0]  stamp;
    logic               place_ok;
    logic [FRAME_W-1:0] place_frame;
  } op_t;

endpackage

`default_nettype wire

/* sv/ptfm_front.sv */
// front end: takes items, holds capacity and frame allocation counter
// depends on ptfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptfm_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  command,
  input  wire logic [ptfm_pkg::PAGE_W-1:0] page,
  input  wire logic [ptfm_pkg::PAGE_W-1:0] victim_page,
  input  wire logic                        flag_value,
  input  wire logic [ptfm_pkg::TIME_W-1:0] current_time,
  input  wire logic                        cfg_wr_en,
  input  wire logic [ptfm_pkg::CAP_W-1:0]  cfg_wr_data,
  input  wire logic                        clearing,
  input  wire logic                        q_full,
  output logic                             q_push,
  output ptfm_pkg::op_t                    q_data
);
  import ptfm_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] occupied;
  logic [CAP_W-1:0] cap_eff;
  logic             place_ok;
  cmd_t             cmd;

  assign cmd      = cmd_t'(command);
  assign cap_eff  = (capacity > CAP_W'(FRAMES)) ? CAP_W'(FRAMES) : capacity;
  assign place_ok = occupied < cap_eff;
  assign in_stall = clearing || q_full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_data.cmd         = cmd;
    q_data.page        = page;
    q_data.victim      = victim_page;
    q_data.flag        = flag_value;
    q_data.stamp       = current_time;
    q_data.place_ok    = place_ok;
    q_data.place_frame = occupied[FRAME_W-1:0];
  end

  // frames are handed out in order, decided here so the back needs no counter
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      occupied <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (q_push && cmd == CMD_PLACE && place_ok) begin
        occupied <= occupied + CAP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ptfm_queue.sv */
// two-entry queue of classified items between front and back
// depends on ptfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptfm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ptfm_pkg::op_t push_data,
  input  wire logic          pop,
  output ptfm_pkg::op_t      head,
  output logic               full,
  output logic               empty
);
  import ptfm_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ptfm_back.sv */
// back end: page table memory, clearing pass, read-modify-write, result register
// depends on ptfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptfm_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_empty,
  input  wire ptfm_pkg::op_t                q_head,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              status,
  output logic                              valid_res,
  output logic                              dirty,
  output logic                              second_chance,
  output logic [ptfm_pkg::FRAME_W-1:0]      frame,
  output logic [ptfm_pkg::TIME_W-1:0]       load_time,
  output logic [ptfm_pkg::TIME_W-1:0]       last_use
);
  import ptfm_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_REPL} state_t;

  state_t            state;
  logic [PAGE_W-1:0] clr_addr;
  op_t               op;
  entry_t            rd_data;
  entry_t            table_mem [PAGES];

  entry_t            e_new;
  entry_t            victim_e;
  logic              st_new;
  logic              slot_free;
  logic [PAGE_W-1:0] rd_addr;
  logic              wr_en;
  logic [PAGE_W-1:0] wr_addr;
  entry_t            wr_data;

  assign clearing  = state == S_CLEAR;
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign slot_free = !out_valid || !out_stall;
  // replace looks up the victim first to learn which frame it gives up
  assign rd_addr   = (q_head.cmd == CMD_REPLACE) ? q_head.victim : q_head.page;

  always_comb begin
    e_new  = rd_data;
    st_new = 1'b0;
    case (op.cmd)
      CMD_PLACE: begin
        if (op.place_ok) begin
          e_new.frame      = op.place_frame;
          e_new.flags      = LOAD_FLAGS;
          e_new.load_stamp = op.stamp;
          e_new.use_stamp  = op.stamp;
        end else begin
          st_new = 1'b1;
        end
      end
      CMD_REPLACE: begin
        e_new.frame      = rd_data.frame;
        e_new.flags      = LOAD_FLAGS;
        e_new.load_stamp = op.stamp;
        e_new.use_stamp  = op.stamp;
      end
      CMD_TOUCH: begin
        e_new.use_stamp          = op.stamp;
        e_new.flags[FLAG_SECOND] = 1'b1;
      end
      CMD_SET_VALID: e_new.flags[FLAG_VALID] = op.flag;
      CMD_SET_DIRTY: e_new.flags[FLAG_DIRTY] = op.flag;
      default: ;
    endcase
    victim_e                   = rd_data;
    victim_e.flags[FLAG_VALID] = 1'b0;
  end

  // the new page is written after the victim so a self-replace ends valid
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = op.page;
    wr_data = e_new;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_EXEC: begin
        wr_en = slot_free;
        if (op.cmd == CMD_REPLACE) begin
          wr_addr = op.victim;
          wr_data = victim_e;
        end
      end
      S_REPL: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EXEC && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PAGE_W'(1);
          if (clr_addr == PAGE_W'(PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            op    <= q_head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            status        <= st_new;
            valid_res     <= e_new.flags[FLAG_VALID];
            dirty         <= e_new.flags[FLAG_DIRTY];
            second_chance <= e_new.flags[FLAG_SECOND];
            frame         <= e_new.frame;
            load_time     <= e_new.load_stamp;
            last_use      <= e_new.use_stamp;
            state         <= (op.cmd == CMD_REPLACE) ? S_REPL : S_IDLE;
          end
        end
        S_REPL: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/page_table_frame_manager.sv */
// page table with frame allocation; one result per item
// the back takes one item at a time, set by the single-port page table: it reads the
// addressed entry, then writes it (replace writes the victim, then the page)
// a two-entry queue lets the front keep taking items while the back waits on out_stall
// reset: synchronous; afterwards a clearing pass over all 1024 entries zeroes the page table
// and in_stall stays high until it finishes; capacity resets to 256
`timescale 1ns / 1ps
`default_nettype none

module page_table_frame_manager (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   command,
  input  wire logic [ptfm_pkg::PAGE_W-1:0]  page,
  input  wire logic [ptfm_pkg::PAGE_W-1:0]  victim_page,
  input  wire logic                         flag_value,
  input  wire logic [ptfm_pkg::TIME_W-1:0]  current_time,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ptfm_pkg::CAP_W-1:0]   cfg_wr_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              status,
  output logic                              valid_res,
  output logic                              dirty,
  output logic                              second_chance,
  output logic [ptfm_pkg::FRAME_W-1:0]      frame,
  output logic [ptfm_pkg::TIME_W-1:0]       load_time,
  output logic [ptfm_pkg::TIME_W-1:0]       last_use
);
  import ptfm_pkg::*;

  logic clearing;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  op_t  q_data;
  op_t  q_head;

  ptfm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .page         (page),
    .victim_page  (victim_page),
    .flag_value   (flag_value),
    .current_time (current_time),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  ptfm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ptfm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .valid_res     (valid_res),
    .dirty         (dirty),
    .second_chance (second_chance),
    .frame         (frame),
    .load_time     (load_time),
    .last_use      (last_use)
  );

  // no result can exist while the table is still being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("result valid during clearing pass");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  a_queue_empty_after_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> q_empty)
    else $error("item queued during clearing pass");

endmodule

`default_nettype wire

/* dv/frame_table_checker.sv */
// checker for the page table frame manager: watches both channels and the capacity port,
// keeps its own page table and capacity, and compares every result
// depends on ptfm_pkg for widths, table sizes, flag positions and command codes
`timescale 1ns / 1ps

module frame_table_checker
  import ptfm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [2:0]        command,
  input  wire logic [PAGE_W-1:0] page,
  input  wire logic [PAGE_W-1:0] victim_page,
  input  wire logic              flag_value,
  input  wire logic [TIME_W-1:0] current_time,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic              status,
  input  wire logic              valid_res,
  input  wire logic              dirty,
  input  wire logic              second_chance,
  input  wire logic [FRAME_W-1:0] frame,
  input  wire logic [TIME_W-1:0] load_time,
  input  wire logic [TIME_W-1:0] last_use,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen,
  output int                     place_refusals
);

  typedef struct packed {
    logic               refused;
    logic               resident;
    logic               modified;
    logic               referenced;
    logic [FRAME_W-1:0] frame_no;
    logic [TIME_W-1:0]  loaded_at;
    logic [TIME_W-1:0]  used_at;
  } page_report_t;

  logic [FRAME_W-1:0] frame_of_page  [PAGES];
  logic [FLAG_W-1:0]  flags_of_page  [PAGES];
  logic [TIME_W-1:0]  loaded_at_page [PAGES];
  logic [TIME_W-1:0]  used_at_page   [PAGES];
  logic [CAP_W-1:0]   frames_in_use;
  logic [CAP_W-1:0]   capacity;

  page_report_t expected_entries[$];

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] seen,
                                 input logic [TIME_W-1:0] wanted);
    fail_count++;
    $display("%0t result %0d: %s is %0h, expected %0h", $time, results_seen, what, seen,
             wanted);
  endtask

  function automatic void load_page(input logic [PAGE_W-1:0] pg, input logic [FRAME_W-1:0] fr,
                                    input logic [TIME_W-1:0] t);
    frame_of_page[pg]  = fr;
    flags_of_page[pg]  = LOAD_FLAGS;
    loaded_at_page[pg] = t;
    used_at_page[pg]   = t;
  endfunction

  function automatic page_report_t step_page_table(input logic [2:0] cmd,
                                                   input logic [PAGE_W-1:0] pg,
                                                   input logic [PAGE_W-1:0] vic,
                                                   input logic flag,
                                                   input logic [TIME_W-1:0] t);
    page_report_t r;
    logic [CAP_W-1:0] usable;
    logic [FRAME_W-1:0] fr;
    r.refused = 1'b0;
    // capacity above the number of frames saturates
    usable = (capacity > CAP_W'(FRAMES)) ? CAP_W'(FRAMES) : capacity;
    case (cmd)
      CMD_PLACE: begin
        if (frames_in_use < usable) begin
          fr = frames_in_use[FRAME_W-1:0];
          load_page(pg, fr, t);
          frames_in_use = frames_in_use + CAP_W'(1);
        end else begin
          r.refused = 1'b1;
        end
      end
      CMD_REPLACE: begin
        // victim entry gives up its frame whether resident or not
        fr = frame_of_page[vic];
        flags_of_page[vic][FLAG_VALID] = 1'b0;
        load_page(pg, fr, t);
      end
      CMD_TOUCH: begin
        used_at_page[pg] = t;
        flags_of_page[pg][FLAG_SECOND] = 1'b1;
      end
      CMD_SET_VALID: flags_of_page[pg][FLAG_VALID] = flag;
      CMD_SET_DIRTY: flags_of_page[pg][FLAG_DIRTY] = flag;
      default: ;
    endcase
    r.resident   = flags_of_page[pg][FLAG_VALID];
    r.modified   = flags_of_page[pg][FLAG_DIRTY];
    r.referenced = flags_of_page[pg][FLAG_SECOND];
    r.frame_no   = frame_of_page[pg];
    r.loaded_at  = loaded_at_page[pg];
    r.used_at    = used_at_page[pg];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    page_report_t want;
    page_report_t guess;
    if (rst) begin
      for (int i = 0; i < PAGES; i++) begin
        frame_of_page[i]  = '0;
        flags_of_page[i]  = '0;
        loaded_at_page[i] = '0;
        used_at_page[i]   = '0;
      end
      frames_in_use = '0;
      capacity = CAP_RESET;
      expected_entries.delete();
    end else begin
      if (cfg_wr_en === 1'b1) capacity = cfg_wr_data;
      // a result always leaves after its item has been taken, so check before predicting
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        results_seen++;
        if (expected_entries.size() == 0) begin
          report_mismatch("unexpected result, frame", TIME_W'(frame), '0);
        end else begin
          want = expected_entries.pop_front();
          if (status !== want.refused)
            report_mismatch("status", TIME_W'(status), TIME_W'(want.refused));
          if (valid_res !== want.resident)
            report_mismatch("valid_res", TIME_W'(valid_res), TIME_W'(want.resident));
          if (dirty !== want.modified)
            report_mismatch("dirty", TIME_W'(dirty), TIME_W'(want.modified));
          if (second_chance !== want.referenced)
            report_mismatch("second_chance", TIME_W'(second_chance),
                            TIME_W'(want.referenced));
          if (frame !== want.frame_no)
            report_mismatch("frame", TIME_W'(frame), TIME_W'(want.frame_no));
          if (load_time !== want.loaded_at)
            report_mismatch("load_time", load_time, want.loaded_at);
          if (last_use !== want.used_at) report_mismatch("last_use", last_use, want.used_at);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        guess = step_page_table(command, page, victim_page, flag_value, current_time);
        if (guess.refused) place_refusals++;
        expected_entries.push_back(guess);
      end
    end
    pending = expected_entries.size();
  end

endmodule

/* dv/tb_page_table_frame_manager.sv */
// top of the page table frame manager testbench: clock, reset, item and capacity stimulus,
// random pacing on both channels, verdict; depends on ptfm_pkg, the block and
// frame_table_checker
`timescale 1ns / 1ps

module tb_page_table_frame_manager;
  import ptfm_pkg::*;

  // command codes the block does not define; they behave as a read
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [PAGE_W-1:0] PAGE_TOP = PAGE_W'(PAGES - 1);
  localparam logic [TIME_W-1:0] STAMP_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = CMD_READ;
  logic [PAGE_W-1:0] page = '0;
  logic [PAGE_W-1:0] victim_page = '0;
  logic flag_value = 1'b0;
  logic [TIME_W-1:0] current_time = '0;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status;
  logic valid_res;
  logic dirty;
  logic second_chance;
  logic [FRAME_W-1:0] frame;
  logic [TIME_W-1:0] load_time;
  logic [TIME_W-1:0] last_use;

  int fail_count;
  int pending;
  int results_seen;
  int place_refusals;

  int items_sent = 0;
  int settings_used = 0;
  bit gapless = 1'b0;
  logic [PAGE_W-1:0] recent_pages[$];
  logic [TIME_W-1:0] stamp_now = '0;

  page_table_frame_manager u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .page(page), .victim_page(victim_page),
    .flag_value(flag_value), .current_time(current_time),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .valid_res(valid_res), .dirty(dirty),
    .second_chance(second_chance), .frame(frame),
    .load_time(load_time), .last_use(last_use)
  );

  frame_table_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .page(page), .victim_page(victim_page),
    .flag_value(flag_value), .current_time(current_time),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .valid_res(valid_res), .dirty(dirty),
    .second_chance(second_chance), .frame(frame),
    .load_time(load_time), .last_use(last_use),
    .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .place_refusals(place_refusals)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending);
    $display("page_table_frame_manager regression: fail");
    $finish;
  end

  // receiver pacing: short stalls mostly, a few long ones, and stall-free stretches
  initial begin : sink_pacing
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r < 95) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic [PAGE_W-1:0] pg,
                           input logic [PAGE_W-1:0] vic, input logic flag,
                           input logic [TIME_W-1:0] stamp);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (gapless || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    page         <= pg;
    victim_page  <= vic;
    flag_value   <= flag;
    current_time <= stamp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  // wait for every result, let the pipeline empty, then write the capacity
  task automatic settle_then_set_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // mostly pages that were placed lately, so replaces and reads hit live entries
  function automatic logic [PAGE_W-1:0] pick_page();
    if (recent_pages.size() > 0 && $urandom_range(0, 99) < 70)
      return recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    return PAGE_W'($urandom_range(0, PAGES - 1));
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) stamp_now = stamp_now + TIME_W'($urandom_range(1, 20));
    else if (r >= 95) stamp_now = $urandom();
    return stamp_now;
  endfunction

  task automatic send_random_item(input int place_pct);
    int r;
    logic [2:0] cmd;
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] vic;
    r = $urandom_range(0, 99);
    pg = pick_page();
    vic = pick_page();
    if (r < place_pct) cmd = CMD_PLACE;
    else if (r < place_pct + (100 - place_pct) * 2 / 10) cmd = CMD_REPLACE;
    else if (r < place_pct + (100 - place_pct) * 4 / 10) cmd = CMD_READ;
    else if (r < place_pct + (100 - place_pct) * 6 / 10) cmd = CMD_TOUCH;
    else if (r < place_pct + (100 - place_pct) * 7 / 10) cmd = CMD_SET_VALID;
    else if (r < place_pct + (100 - place_pct) * 85 / 100) cmd = CMD_SET_DIRTY;
    else cmd = 3'($urandom_range(0, 7));
    if (cmd == CMD_REPLACE && $urandom_range(0, 9) == 0) vic = pg;
    if (cmd == CMD_PLACE) begin
      recent_pages.push_back(pg);
      if (recent_pages.size() > 64) void'(recent_pages.pop_front());
    end
    send_item(cmd, pg, vic, 1'($urandom_range(0, 1)), next_stamp());
  endtask

  initial begin : stimulus
    int phase_cap[7]   = '{511, 16, 256, 0, 300, 100, 511};
    int phase_items[7] = '{180, 150, 250, 150, 200, 150, 200};
    int phase_place[7] = '{30, 30, 80, 30, 30, 30, 30};
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset holds the input stalled
    do @(posedge clk); while (in_stall !== 1'b0);
    settle_then_set_capacity(CAP_W'(256));

    send_item(CMD_READ, '0, '0, 1'b0, '0);
    send_item(CMD_READ, PAGE_TOP, PAGE_TOP, 1'b1, STAMP_TOP);
    send_item(CMD_PLACE, '0, PAGE_TOP, 1'b0, '0);
    send_item(CMD_PLACE, PAGE_TOP, '0, 1'b1, STAMP_TOP);
    send_item(CMD_PLACE, '0, '0, 1'b0, 32'd5);                  // resident page, new frame
    send_item(CMD_TOUCH, PAGE_TOP, '0, 1'b0, 32'h8000_0001);
    send_item(CMD_TOUCH, 10'd500, '0, 1'b0, 32'd7);            // touch of an absent page
    send_item(CMD_SET_DIRTY, PAGE_TOP, '0, 1'b1, '0);
    send_item(CMD_SET_DIRTY, PAGE_TOP, '0, 1'b0, STAMP_TOP);
    send_item(CMD_SET_VALID, 10'd500, '0, 1'b1, '0);
    send_item(CMD_SET_VALID, 10'd500, '0, 1'b0, '0);
    send_item(CMD_REPLACE, 10'd7, PAGE_TOP, 1'b0, 32'd9);
    send_item(CMD_READ, PAGE_TOP, '0, 1'b0, '0);
    send_item(CMD_REPLACE, 10'd8, 10'd600, 1'b0, 32'd10);      // victim never placed
    send_item(CMD_REPLACE, 10'd9, 10'd9, 1'b0, 32'd11);        // victim is the page itself
    send_item(CMD_SPARE_A, '0, PAGE_TOP, 1'b1, STAMP_TOP);
    send_item(CMD_SPARE_B, PAGE_TOP, PAGE_TOP, 1'b1, STAMP_TOP);
    // three frames taken: room for one more, then full
    settle_then_set_capacity(CAP_W'(4));
    send_item(CMD_PLACE, 10'd300, '0, 1'b0, 32'd20);
    send_item(CMD_PLACE, 10'd301, '0, 1'b0, 32'd21);
    settle_then_set_capacity(CAP_W'(0));
    send_item(CMD_PLACE, 10'd302, '0, 1'b0, 32'd22);
    settle_then_set_capacity(CAP_W'(511));
    send_item(CMD_PLACE, 10'd303, '0, 1'b0, 32'd23);
    send_item(CMD_READ, 10'd303, '0, 1'b0, '0);
    stamp_now = 32'd100;

    for (int p = 0; p < 7; p++) begin
      settle_then_set_capacity(CAP_W'(phase_cap[p]));
      for (int i = 0; i < phase_items[p]; i++) begin
        if (i % 50 == 0) gapless = ($urandom_range(0, 3) == 0);
        send_random_item(phase_place[p]);
      end
      gapless = 1'b0;
    end

    in_valid <= 1'b0;
    k = 0;
    do begin
      @(posedge clk);
      k++;
    end while (pending != 0 && k < 20000);
    repeat (10) @(posedge clk);
    $display("run covered %0d items under %0d capacity settings, including empty and full",
             items_sent, settings_used);
    $display("%0d results compared, %0d placements refused for want of a frame",
             results_seen, place_refusals);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("page_table_frame_manager regression: pass");
    end else begin
      $display("page_table_frame_manager regression: fail");
    end
    $finish;
  end

endmodule

/* page_table_frame_manager.f */
sv/ptfm_pkg.sv
sv/ptfm_front.sv
sv/ptfm_queue.sv
sv/ptfm_back.sv
sv/page_table_frame_manager.sv
dv/frame_table_checker.sv
dv/tb_page_table_frame_manager.sv
